// File: hdl/dobc_pkg.sv
// shared types, constants and permutation functions of the overlapping buffer cipher
package dobc_pkg;

   localparam int DEFAULT_MAX_BYTES = 128;

   // configuration register indexes
   localparam logic REG_DES_KEY      = 1'b0;
   localparam logic REG_DECRYPT_MODE = 1'b1;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_SHORT    = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   // window geometry
   localparam int WIN_BYTES  = 8;
   localparam int WIN_STRIDE = 7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [63:0] data_word;
      logic [3:0]  valid_bytes;
      logic        last_word;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WSEL,
      ST_RD,
      ST_DES,
      ST_WR,
      ST_OUT_RD,
      ST_OUT_SEND
   } state_type;

   localparam logic [6:0] IP_TAB [0:63] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
      64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam logic [6:0] FP_TAB [0:63] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam logic [5:0] E_TAB [0:47] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam logic [5:0] P_TAB [0:31] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam logic [6:0] PC1_TAB [0:55] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,
      61,53,45,37,29,21,13,5,28,20,12,4};
   localparam logic [5:0] PC2_TAB [0:47] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   // one means a two-bit rotation in that round
   localparam logic ROT2_TAB [0:15] = '{0,0,1,1,1,1,1,1,0,1,1,1,1,1,1,0};
   localparam logic [3:0] S_TAB [0:7][0:63] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // table entries count from 1 at the most significant bit
   function automatic logic [63:0] perm_ip(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-int'(IP_TAB[i])];
      return o;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-int'(FP_TAB[i])];
      return o;
   endfunction

   function automatic logic [47:0] perm_e(input logic [31:0] x);
      logic [47:0] o;
      for (int i = 0; i < 48; i++) o[47-i] = x[32-int'(E_TAB[i])];
      return o;
   endfunction

   function automatic logic [31:0] perm_p(input logic [31:0] x);
      logic [31:0] o;
      for (int i = 0; i < 32; i++) o[31-i] = x[32-int'(P_TAB[i])];
      return o;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] x);
      logic [55:0] o;
      for (int i = 0; i < 56; i++) o[55-i] = x[64-int'(PC1_TAB[i])];
      return o;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] x);
      logic [47:0] o;
      for (int i = 0; i < 48; i++) o[47-i] = x[56-int'(PC2_TAB[i])];
      return o;
   endfunction

   function automatic logic [31:0] sbox_layer(input logic [47:0] x);
      logic [31:0] o;
      logic [5:0]  six;
      for (int j = 0; j < 8; j++) begin
         six = x[47-6*j -: 6];
         o[31-4*j -: 4] = S_TAB[j][{six[5], six[0], six[4:1]}];
      end
      return o;
   endfunction

   function automatic logic [27:0] rotl28(input logic [27:0] x, input logic two);
      return two ? {x[25:0], x[27:26]} : {x[26:0], x[27]};
   endfunction

   function automatic logic [27:0] rotr28(input logic [27:0] x, input logic two);
      return two ? {x[1:0], x[27:2]} : {x[0], x[27:1]};
   endfunction

   // spread 56 key bits into 8 key bytes; parity bits are dropped by pc1
   function automatic logic [63:0] key_bytes(input logic [55:0] k);
      logic [63:0] o;
      for (int i = 0; i < 8; i++) o[63-8*i -: 8] = {k[55-7*i -: 7], 1'b0};
      return o;
   endfunction

endpackage

// File: hdl/dobc_ram.sv
// generic single-port-write, registered-read ram
module dobc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/dobc_des_core.sv
// iterative des unit: one round per cycle, subkeys rolled alongside
module dobc_des_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        dec,
   input  logic [55:0] key,
   input  logic [63:0] blk_in,
   output logic        done,
   output logic [63:0] blk_out
);
   import dobc_pkg::*;

   logic [31:0] l_ff, l_in, r_ff, r_in;
   logic [55:0] cd_ff, cd_in;
   logic [3:0]  round_ff, round_in;
   logic        busy_ff, busy_in, done_ff, done_in, dec_ff, dec_in;
   logic [63:0] ip_blk;
   logic [55:0] cd_rot;
   logic [55:0] cd_key;
   logic [47:0] subkey;
   logic [31:0] f_out;

   // key rotation for the current round
   always_comb begin
      cd_rot = {rotl28(cd_ff[55:28], ROT2_TAB[round_ff]),
                rotl28(cd_ff[27:0], ROT2_TAB[round_ff])};
      if (dec_ff) begin
         cd_key = cd_ff;
      end else begin
         cd_key = cd_rot;
      end
      subkey = perm_pc2(cd_key);
      f_out  = perm_p(sbox_layer(perm_e(r_ff) ^ subkey));
      ip_blk = perm_ip(blk_in);
   end

   // round sequencing
   always_comb begin
      l_in     = l_ff;
      r_in     = r_ff;
      cd_in    = cd_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      dec_in   = dec_ff;
      done_in  = 1'b0;
      if (start) begin
         l_in     = ip_blk[63:32];
         r_in     = ip_blk[31:0];
         cd_in    = perm_pc1(key_bytes(key));
         round_in = '0;
         busy_in  = 1'b1;
         dec_in   = dec;
      end else if (busy_ff) begin
         l_in = r_ff;
         r_in = f_out ^ l_ff;
         if (dec_ff) begin
            cd_in = {rotr28(cd_ff[55:28], ROT2_TAB[4'd15 - round_ff]),
                     rotr28(cd_ff[27:0], ROT2_TAB[4'd15 - round_ff])};
         end else begin
            cd_in = cd_rot;
         end
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      l_ff   <= l_in;
      r_ff   <= r_in;
      cd_ff  <= cd_in;
      dec_ff <= dec_in;
   end

   assign done    = done_ff;
   assign blk_out = perm_fp({r_ff, l_ff});

   // done follows the sixteenth round
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && $past(round_ff) == 4'd15)
      else $error("des done without final round");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !done_ff)
      else $error("des done while still busy");
   a_round_zero_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && round_ff == 4'd0)
      else $error("des start did not begin at round zero");

endmodule

// File: hdl/des_overlapping_buffer_cipher.sv
// top level: message store, window sequencer and output word assembly
//
// Usage: message bytes arrive on the req_ channel, one transaction per byte,
// with last marking the final byte. Each byte takes one cycle. After the last
// byte the block stops taking transactions (req_stall high), runs DES in
// place over overlapping 8-byte windows at stride 7 (forward order to
// encrypt, reverse order to decrypt) and then returns the message as 8-byte
// words on the rsp_ channel, the final word flagged by last_word.
// Sequence: a stride scan over the message, then per window a select step,
// a read of its bytes, the rounds in the shared DES round unit and a write
// back, through the one read and one write port of the byte store; then per
// output word a gather of its bytes and its transfer on the rsp_ channel,
// which waits while rsp_stall is high.
// Messages under 8 bytes come back unchanged with short status; bytes beyond
// MAX_BYTES are dropped and overflow status is given.
// A stalled rsp_ transaction holds its word until taken. Reset returns to
// loading with an empty message; key and mode reset to zero. The store needs
// no clearing pass since store bytes beyond the current message are sent as zero.
module des_overlapping_buffer_cipher #(
   parameter int MAX_BYTES = dobc_pkg::DEFAULT_MAX_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dobc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dobc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [55:0]       csr_wdata
);
   import dobc_pkg::*;

   localparam int CW = $clog2(MAX_BYTES + 1);
   localparam int AW = $clog2(MAX_BYTES);
   localparam int SW = $clog2(MAX_BYTES + 16);

   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [55:0]   key_ff, key_in;
   logic          mode_ff, mode_in;
   logic [CW-1:0] fwd_ff, fwd_in, win_ff, win_in, last_off_ff, last_off_in;
   logic [CW-1:0] base_ff, base_in;
   logic          fwd_done_ff, fwd_done_in, tail_ff, tail_in;
   logic [1:0]    stat_ff, stat_in;
   logic [63:0]   blk_ff, blk_in;
   logic [3:0]    k_ff, k_in;
   rsp_type       rsp_ff, rsp_in;

   logic          req_acc, rsp_acc;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic          des_start, des_done;
   logic [63:0]   des_out, gather_blk;
   logic [SW-1:0] len_x, fwd_x, rd_sum;
   logic [CW-1:0] rem_bytes;
   logic [3:0]    n_bytes;
   logic [7:0]    out_byte;
   logic          len_short, scan_more, out_last;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   // length and offset arithmetic
   always_comb begin
      len_x     = SW'(cnt_ff);
      fwd_x     = SW'(fwd_ff);
      len_short = cnt_ff < CW'(WIN_BYTES);
      scan_more = (fwd_x + SW'(WIN_BYTES + WIN_STRIDE)) <= len_x;
      rem_bytes = cnt_ff - base_ff;
      n_bytes   = (rem_bytes > CW'(WIN_BYTES)) ? 4'(WIN_BYTES) : rem_bytes[3:0];
      out_last  = (SW'(base_ff) + SW'(WIN_BYTES)) >= len_x;
      out_byte  = ((k_ff - 4'd1) < n_bytes) ? ram_rdata : 8'd0;
      gather_blk = {blk_ff[55:0], ram_rdata};
   end

   // store address selection
   always_comb begin
      if (state_ff == ST_OUT_RD) begin
         rd_sum = SW'(base_ff) + SW'(k_ff);
      end else begin
         rd_sum = SW'(win_ff) + SW'(k_ff);
      end
      ram_raddr = rd_sum[AW-1:0];
      if (state_ff == ST_WR) begin
         ram_we    = 1'b1;
         ram_waddr = AW'(win_ff + CW'(k_ff));
         ram_wdata = blk_ff[63:56];
      end else begin
         ram_we    = req_acc && (cnt_ff < CW'(MAX_BYTES));
         ram_waddr = cnt_ff[AW-1:0];
         ram_wdata = req_data.data_byte;
      end
   end

   assign des_start = (state_ff == ST_RD) && (k_ff == 4'd8);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_data.last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (len_short) state_in = ST_OUT_RD;
            else if (!scan_more) state_in = ST_WSEL;
         end
         ST_WSEL: begin
            if (fwd_done_ff && !tail_ff) state_in = ST_OUT_RD;
            else state_in = ST_RD;
         end
         ST_RD: begin
            if (k_ff == 4'd8) state_in = ST_DES;
         end
         ST_DES: begin
            if (des_done) state_in = ST_WR;
         end
         ST_WR: begin
            if (k_ff == 4'd7) state_in = ST_WSEL;
         end
         ST_OUT_RD: begin
            if (k_ff == 4'd8) state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_acc) state_in = rsp_ff.last_word ? ST_IDLE : ST_OUT_RD;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath register updates
   always_comb begin
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      key_in      = key_ff;
      mode_in     = mode_ff;
      fwd_in      = fwd_ff;
      win_in      = win_ff;
      last_off_in = last_off_ff;
      base_in     = base_ff;
      fwd_done_in = fwd_done_ff;
      tail_in     = tail_ff;
      stat_in     = stat_ff;
      blk_in      = blk_ff;
      k_in        = k_ff;
      rsp_in      = rsp_ff;
      // configuration writes
      if (csr_we) begin
         if (csr_index == REG_DES_KEY) key_in = csr_wdata;
         else mode_in = csr_wdata[0];
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (cnt_ff < CW'(MAX_BYTES)) cnt_in = cnt_ff + CW'(1);
               else ovf_in = 1'b1;
            end
            fwd_in  = '0;
            base_in = '0;
            k_in    = '0;
         end
         ST_SCAN: begin
            // walk forward windows to find the last stride offset
            stat_in = len_short ? STAT_SHORT : (ovf_ff ? STAT_OVERFLOW : STAT_OK);
            if (scan_more) begin
               fwd_in = fwd_ff + CW'(WIN_STRIDE);
            end else begin
               last_off_in = fwd_ff;
               tail_in     = (fwd_x + SW'(WIN_BYTES)) != len_x;
               fwd_done_in = 1'b0;
               if (!mode_ff) fwd_in = '0;
            end
            k_in = '0;
         end
         ST_WSEL: begin
            k_in = '0;
            if (!mode_ff) begin
               if (!fwd_done_ff) begin
                  win_in = fwd_ff;
                  if (fwd_ff == last_off_ff) fwd_done_in = 1'b1;
                  else fwd_in = fwd_ff + CW'(WIN_STRIDE);
               end else if (tail_ff) begin
                  win_in  = cnt_ff - CW'(WIN_BYTES);
                  tail_in = 1'b0;
               end
            end else begin
               if (tail_ff) begin
                  win_in  = cnt_ff - CW'(WIN_BYTES);
                  tail_in = 1'b0;
               end else if (!fwd_done_ff) begin
                  win_in = fwd_ff;
                  if (fwd_ff == '0) fwd_done_in = 1'b1;
                  else fwd_in = fwd_ff - CW'(WIN_STRIDE);
               end
            end
         end
         ST_RD: begin
            if (k_ff != 4'd0) blk_in = gather_blk;
            k_in = k_ff + 4'd1;
         end
         ST_DES: begin
            k_in = '0;
            if (des_done) blk_in = des_out;
         end
         ST_WR: begin
            blk_in = {blk_ff[55:0], 8'd0};
            k_in   = k_ff + 4'd1;
         end
         ST_OUT_RD: begin
            if (k_ff != 4'd0) blk_in = {blk_ff[55:0], out_byte};
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd8) begin
               rsp_in.data_word   = {blk_ff[55:0], out_byte};
               rsp_in.valid_bytes = n_bytes;
               rsp_in.last_word   = out_last;
               rsp_in.status      = stat_ff;
            end
         end
         ST_OUT_SEND: begin
            k_in = '0;
            if (rsp_acc) begin
               if (rsp_ff.last_word) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  base_in = base_ff + CW'(WIN_BYTES);
               end
            end
         end
         default: begin
            k_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         key_ff   <= '0;
         mode_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         key_ff   <= key_in;
         mode_ff  <= mode_in;
         k_ff     <= k_in;
      end
      fwd_ff      <= fwd_in;
      win_ff      <= win_in;
      last_off_ff <= last_off_in;
      base_ff     <= base_in;
      fwd_done_ff <= fwd_done_in;
      tail_ff     <= tail_in;
      stat_ff     <= stat_in;
      blk_ff      <= blk_in;
      rsp_ff      <= rsp_in;
   end

   // byte store
   dobc_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared des round unit
   dobc_des_core u_des (
      .clock   (clock),
      .reset   (reset),
      .start   (des_start),
      .dec     (mode_ff),
      .key     (key_ff),
      .blk_in  (gather_blk),
      .done    (des_done),
      .blk_out (des_out)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT_SEND);
   assign rsp_data  = rsp_ff;

   a_valid_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ff.valid_bytes >= 4'd1 && rsp_ff.valid_bytes <= 4'd8)
      else $error("word byte count out of range");
   a_des_done_in_des: assert property (@(posedge clock) disable iff (reset)
      des_done |-> state_ff == ST_DES)
      else $error("des finished outside of des state");
   a_window_in_store: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WR |-> SW'(win_ff) + SW'(WIN_BYTES) <= len_x)
      else $error("window runs past message end");
   a_count_nonzero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("word sent for an empty message");

endmodule
